// ===== rtl/core/klerp_pkg.sv =====
package klerp_pkg;

  localparam int TableDepth = 16;
  localparam int MaxKey     = 16;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int LenW       = $clog2(TableDepth + 1);
  localparam int KeyW       = 5;
  localparam int DataW      = 16;
  localparam int FracW      = 16;

  // request kinds
  localparam logic [1:0] ACT_QUERY   = 2'd0;
  localparam logic [1:0] ACT_POINT   = 2'd1;
  localparam logic [1:0] ACT_DEFAULT = 2'd2;

  // result source codes
  localparam logic [1:0] SRC_DEFAULT = 2'd0;
  localparam logic [1:0] SRC_SINGLE  = 2'd1;
  localparam logic [1:0] SRC_INTERP  = 2'd2;

  // best-below / best-above candidates carried down the cell chain
  typedef struct packed {
    logic             lo_v;
    logic [DataW-1:0] lo_d;
    logic [DataW-1:0] lo_yaw;
    logic [DataW-1:0] lo_ten;
    logic             hi_v;
    logic [DataW-1:0] hi_d;
    logic [DataW-1:0] hi_yaw;
    logic [DataW-1:0] hi_ten;
  } cand_t;

endpackage

// ===== rtl/core/klerp_cell.sv =====
module klerp_cell
  import klerp_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [KeyW-1:0]  wr_key,
  input  logic [DataW-1:0] wr_d,
  input  logic [DataW-1:0] wr_yaw,
  input  logic [DataW-1:0] wr_ten,
  input  logic             active,
  input  logic [KeyW-1:0]  q_key,
  input  logic [DataW-1:0] q_d,
  input  cand_t            cand_in,
  output cand_t            cand_out
);

  logic [KeyW-1:0]  key_r;
  logic [DataW-1:0] d_r;
  logic [DataW-1:0] yaw_r;
  logic [DataW-1:0] ten_r;
  cand_t            cand_r;
  cand_t            cand_nxt;
  logic             hit;

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r <= wr_key;
      d_r   <= wr_d;
      yaw_r <= wr_yaw;
      ten_r <= wr_ten;
    end
  end

  // strict improvement only, so the lowest slot wins a tie
  always_comb begin
    cand_nxt = cand_in;
    hit      = active && (key_r == q_key);
    if (hit && ($signed(d_r) <= $signed(q_d)) &&
        (!cand_in.lo_v || ($signed(d_r) > $signed(cand_in.lo_d)))) begin
      cand_nxt.lo_v   = 1'b1;
      cand_nxt.lo_d   = d_r;
      cand_nxt.lo_yaw = yaw_r;
      cand_nxt.lo_ten = ten_r;
    end
    if (hit && ($signed(d_r) >= $signed(q_d)) &&
        (!cand_in.hi_v || ($signed(d_r) < $signed(cand_in.hi_d)))) begin
      cand_nxt.hi_v   = 1'b1;
      cand_nxt.hi_d   = d_r;
      cand_nxt.hi_yaw = yaw_r;
      cand_nxt.hi_ten = ten_r;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;

endmodule

// ===== rtl/core/klerp_div.sv =====
module klerp_div
  import klerp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DataW-1:0] num,
  input  logic [DataW-1:0] den,
  output logic             done,
  output logic [FracW-1:0] quo
);

  localparam int CntW = $clog2(FracW);

  logic             busy_r;
  logic [CntW-1:0]  cnt_r;
  logic [DataW-1:0] rem_r;
  logic [DataW-1:0] den_r;
  logic [FracW-1:0] quo_r;
  logic             done_r;
  logic [DataW:0]   rem2;
  logic [DataW:0]   diff;

  // one quotient bit per cycle, remainder stays below the divisor
  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(FracW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      if (!diff[DataW]) begin
        rem_r <= diff[DataW-1:0];
        quo_r <= {quo_r[FracW-2:0], 1'b1};
      end else begin
        rem_r <= rem2[DataW-1:0];
        quo_r <= {quo_r[FracW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/keyed_table_linear_interpolator.sv =====
// Keyed table interpolator. A trivial query takes its default entry without a
// search; otherwise the search record walks the 16-cell chain, one cell per
// cycle, is evaluated and then handed to the output register. An
// interpolation adds the bit-serial fraction divider (16 steps, then the
// quotient is handed over) and a multiply state and an add state. A finished
// result sits in the output register, and a new request is taken while it
// waits.
module keyed_table_linear_interpolator
  import klerp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LenW-1:0]  cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_action,
  input  logic [SlotW-1:0] in_slot,
  input  logic [KeyW-1:0]  in_key_id,
  input  logic [DataW-1:0] in_distance_in,
  input  logic [DataW-1:0] in_yaw_in,
  input  logic [DataW-1:0] in_tension_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DataW-1:0] out_yaw_out,
  output logic [DataW-1:0] out_tension_out,
  output logic [1:0]       out_source
);

  localparam int CntW = $clog2(TableDepth);
  localparam int ProdW = DataW + 1 + FracW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CntW-1:0]  cnt_r;
  logic [LenW-1:0]  len_r;
  logic [KeyW-1:0]  q_key_r;
  logic [DataW-1:0] q_d_r;
  logic [DataW-1:0] def_yaw_r [0:MaxKey];
  logic [DataW-1:0] def_ten_r [0:MaxKey];
  logic [DataW-1:0] res_yaw_r;
  logic [DataW-1:0] res_ten_r;
  logic [1:0]       res_src_r;
  logic             out_valid_r;
  logic [DataW-1:0] out_yaw_r;
  logic [DataW-1:0] out_ten_r;
  logic [1:0]       out_src_r;
  logic signed [ProdW-1:0] prod_yaw_r;
  logic signed [ProdW-1:0] prod_ten_r;

  logic             accept;
  logic             is_query;
  logic [KeyW-1:0]  q_key;
  logic             q_trivial;
  cand_t            chain [0:TableDepth];
  cand_t            fin;
  logic             div_start;
  logic             div_done;
  logic [FracW-1:0] k;
  logic [DataW-1:0] num;
  logic [DataW-1:0] den;
  logic signed [DataW:0] dyaw;
  logic signed [DataW:0] dten;
  logic signed [ProdW-1:0] mag_yaw;
  logic signed [ProdW-1:0] mag_ten;
  logic signed [DataW:0]   t_yaw;
  logic signed [DataW:0]   t_ten;
  logic             out_free;

  assign accept   = in_valid && !in_stall;
  assign is_query = in_action == ACT_QUERY;
  assign in_stall = state_r != ST_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  // query key outside 1..MaxKey falls to key 0
  assign q_key = ((in_key_id >= KeyW'(1)) && (in_key_id <= KeyW'(MaxKey))) ?
                 in_key_id : '0;
  assign q_trivial = (q_key == '0) || $signed(in_distance_in) <= 0 || len_r == '0;

  // cell chain: candidates advance one cell per cycle
  assign chain[0] = '0;
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    klerp_cell u_cell (
      .clk      (clk),
      .wr_en    (accept && in_action == ACT_POINT && in_slot == SlotW'(i)),
      .wr_key   (in_key_id),
      .wr_d     (in_distance_in),
      .wr_yaw   (in_yaw_in),
      .wr_ten   (in_tension_in),
      .active   (LenW'(i) < len_r),
      .q_key    (q_key_r),
      .q_d      (q_d_r),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end
  assign fin = chain[TableDepth];

  // fraction divide: lo_d < d < hi_d, so num < den
  assign num = q_d_r - fin.lo_d;
  assign den = fin.hi_d - fin.lo_d;
  assign div_start = (state_r == ST_EVAL) && fin.lo_v && fin.hi_v &&
                     (fin.lo_d != fin.hi_d);

  klerp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (k)
  );

  // differences for the interpolation
  assign dyaw = $signed({fin.hi_yaw[DataW-1], fin.hi_yaw}) -
                $signed({fin.lo_yaw[DataW-1], fin.lo_yaw});
  assign dten = $signed({1'b0, fin.hi_ten}) - $signed({1'b0, fin.lo_ten});

  // truncate toward zero after the Q0.16 scale
  assign mag_yaw = prod_yaw_r[ProdW-1] ? -prod_yaw_r : prod_yaw_r;
  assign mag_ten = prod_ten_r[ProdW-1] ? -prod_ten_r : prod_ten_r;
  assign t_yaw = prod_yaw_r[ProdW-1] ? -$signed(mag_yaw[FracW +: DataW+1]) :
                 $signed(mag_yaw[FracW +: DataW+1]);
  assign t_ten = prod_ten_r[ProdW-1] ? -$signed(mag_ten[FracW +: DataW+1]) :
                 $signed(mag_ten[FracW +: DataW+1]);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query) state_nxt = q_trivial ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == CntW'(TableDepth - 1)) state_nxt = ST_EVAL;
      end
      ST_EVAL: state_nxt = div_start ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_done) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SCAN) cnt_r <= cnt_r + 1'b1;
      else cnt_r <= '0;
      if (cfg_we) begin
        len_r <= (cfg_wdata > LenW'(TableDepth)) ? LenW'(TableDepth) : cfg_wdata;
      end
    end
  end

  // default entries, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= MaxKey; j++) begin
        def_yaw_r[j] <= '0;
        def_ten_r[j] <= '0;
      end
    end else if (accept && in_action == ACT_DEFAULT &&
                 in_key_id <= KeyW'(MaxKey)) begin
      def_yaw_r[in_key_id] <= in_yaw_in;
      def_ten_r[in_key_id] <= in_tension_in;
    end
  end

  // query latch and result staging
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      q_key_r   <= q_key;
      q_d_r     <= in_distance_in;
      res_yaw_r <= def_yaw_r[q_key];
      res_ten_r <= def_ten_r[q_key];
      res_src_r <= SRC_DEFAULT;
    end
    if (state_r == ST_EVAL) begin
      if (fin.lo_v) begin
        res_yaw_r <= fin.lo_yaw;
        res_ten_r <= fin.lo_ten;
        res_src_r <= SRC_SINGLE;
      end else if (fin.hi_v) begin
        res_yaw_r <= fin.hi_yaw;
        res_ten_r <= fin.hi_ten;
        res_src_r <= SRC_SINGLE;
      end else begin
        res_yaw_r <= def_yaw_r[q_key_r];
        res_ten_r <= def_ten_r[q_key_r];
        res_src_r <= SRC_DEFAULT;
      end
    end
    if (state_r == ST_MUL) begin
      prod_yaw_r <= ProdW'(dyaw * $signed({1'b0, k}));
      prod_ten_r <= ProdW'(dten * $signed({1'b0, k}));
    end
    if (state_r == ST_ADD) begin
      res_yaw_r <= fin.lo_yaw + t_yaw[DataW-1:0];
      res_ten_r <= fin.lo_ten + t_ten[DataW-1:0];
      res_src_r <= SRC_INTERP;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_yaw_r <= res_yaw_r;
      out_ten_r <= res_ten_r;
      out_src_r <= res_src_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_yaw_out     = out_yaw_r;
  assign out_tension_out = out_ten_r;
  assign out_source      = out_src_r;

endmodule
